// ----- src/tuvm_pkg.sv -----
// ----------------------------------------------------------------------------
// tuvm_pkg
// Shared types, constants and helpers for the texture coordinate mapper.
// ----------------------------------------------------------------------------
package tuvm_pkg;

    localparam int DATA_W           = 20;
    localparam int GUARD_BITS       = 12;
    localparam int SQ_W             = 64;
    localparam int SQRT_STEPS       = 32;
    localparam int ROOT_W           = 33;
    localparam int ANG_W            = 36;
    localparam int TBL_SIZE         = 30;
    localparam int WIDE_W           = 40;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    localparam logic signed [ANG_W-1:0] PI_Q30     = 36'sd3373259426;
    localparam logic [30:0]             INV_PI_Q32 = 31'd1367130551;

    typedef enum logic [1:0] {
        MODE_SPHERE   = 2'd0,
        MODE_PLANE    = 2'd1,
        MODE_CYLINDER = 2'd2,
        MODE_CUBE     = 2'd3
    } map_mode_t;

    // payload carried down the root chain
    typedef struct packed {
        logic                     sphere;
        logic                     cordic;
        logic signed [DATA_W-1:0] u_alt;
        logic signed [DATA_W-1:0] v_alt;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } tag_t;

    // payload carried down the rotator chain
    typedef struct packed {
        logic                     sphere;
        logic                     cordic;
        logic                     zero_u;
        logic                     zero_v;
        logic signed [DATA_W-1:0] u_alt;
        logic signed [DATA_W-1:0] v_alt;
    } ctag_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] a;
    } lane_t;

    // arctan(2^-idx) in Q30 radians
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:       r = 36'sd843314857;
            1:       r = 36'sd497837829;
            2:       r = 36'sd263043837;
            3:       r = 36'sd133525159;
            4:       r = 36'sd67021687;
            5:       r = 36'sd33543516;
            6:       r = 36'sd16775851;
            7:       r = 36'sd8388437;
            8:       r = 36'sd4194283;
            9:       r = 36'sd2097149;
            default: r = ANG_W'(64'd1 << (30 - idx));
        endcase
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat20(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 40'sd524287)
            r = 20'sh7FFFF;
        else if (v < -40'sd524288)
            r = 20'sh80000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ----- src/tuvm_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// tuvm_sqrt_cell
// One restoring square-root step; settles one result bit per cell.
// ----------------------------------------------------------------------------
module tuvm_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  tuvm_pkg::tag_t          in_tag,
    input  logic [63:0]             in_rem,
    input  logic [63:0]             in_root,
    output logic                    out_valid,
    output tuvm_pkg::tag_t          out_tag,
    output logic [63:0]             out_rem,
    output logic [63:0]             out_root
);
    import tuvm_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * STEP);

    logic            valid_reg;
    tag_t            tag_reg;
    logic [SQ_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0] root_reg, root_next;
    logic [SQ_W-1:0] trial;

    always_comb
    begin
        trial = in_root + BIT;
        if (in_rem >= trial)
        begin
            rem_next  = in_rem - trial;
            root_next = (in_root >> 1) + BIT;
        end
        else
        begin
            rem_next  = in_rem;
            root_next = in_root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg  <= in_tag;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

// ----- src/tuvm_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// tuvm_cordic_cell
// One vectoring micro-rotation for both the u and the v angle lanes.
// ----------------------------------------------------------------------------
module tuvm_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  tuvm_pkg::ctag_t in_tag,
    input  tuvm_pkg::lane_t in_u,
    input  tuvm_pkg::lane_t in_v,
    output logic            out_valid,
    output tuvm_pkg::ctag_t out_tag,
    output tuvm_pkg::lane_t out_u,
    output tuvm_pkg::lane_t out_v
);
    import tuvm_pkg::*;

    localparam logic signed [ANG_W-1:0] ANG = atan_entry(IDX);

    function automatic lane_t rotate(input lane_t l);
        lane_t r;
        if (!l.y[ANG_W-1])
        begin
            r.x = l.x + (l.y >>> IDX);
            r.y = l.y - (l.x >>> IDX);
            r.a = l.a + ANG;
        end
        else
        begin
            r.x = l.x - (l.y >>> IDX);
            r.y = l.y + (l.x >>> IDX);
            r.a = l.a - ANG;
        end
        return r;
    endfunction

    logic  valid_reg;
    ctag_t tag_reg;
    lane_t u_reg;
    lane_t v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg <= in_tag;
            u_reg   <= rotate(in_u);
            v_reg   <= rotate(in_v);
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_u     = u_reg;
    assign out_v     = v_reg;

endmodule

// ----- src/texture_uv_mapper.sv -----
// ----------------------------------------------------------------------------
// texture_uv_mapper
// Maps a local hit point to texture coordinates (sphere/plane/cylinder/cube).
// ----------------------------------------------------------------------------
//  channel   signals                          transfer when
//  input     in_valid, in_ready, hit_x/y/z    in_valid & in_ready
//  output    out_valid, out_ready, tex_u/v    out_valid & out_ready
//  config    cfg_we, cfg_wdata (map_mode)     cfg_we
//
//  One item per cycle while the output is not stalled; stages in order: input stage,
//  32 root cells, prescale stage, CORDIC_STEPS rotator cells, multiply, output reg.
//  rst_n clears the valid bits of every stage and map_mode to sphere.
//  A stalled output freezes the whole chain; in_ready is low only then.
// ----------------------------------------------------------------------------
module texture_uv_mapper #(
    parameter int FRAC_BITS    = tuvm_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = tuvm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tuvm_pkg::DATA_W-1:0]  hit_x,
    input  logic signed [tuvm_pkg::DATA_W-1:0]  hit_y,
    input  logic signed [tuvm_pkg::DATA_W-1:0]  hit_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tuvm_pkg::DATA_W-1:0]  tex_u,
    output logic signed [tuvm_pkg::DATA_W-1:0]  tex_v
);
    import tuvm_pkg::*;

    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] QTR  = ONE >>> 2;
    localparam int                 SH_U = 62 - FRAC_BITS;
    localparam int                 SH_V = 61 - FRAC_BITS;
    localparam int                 P_W  = 67;

    logic      en;
    map_mode_t mode_reg;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_SPHERE;
        else if (cfg_we)
            mode_reg <= map_mode_t'(cfg_wdata);
    end

    // ---------------- input stage: direct modes and squared radius ---------
    logic signed [31:0] xe, ye, ze, cu, cv;
    logic [19:0]        ax, ay;
    logic [39:0]        px, py;
    logic [SQ_W-1:0]    sq;
    tag_t               tag_in;

    always_comb
    begin
        xe = 32'(hit_x);
        ye = 32'(hit_y);
        ze = 32'(hit_z);
        ax = xe[31] ? 20'(-xe) : 20'(xe);
        ay = ye[31] ? 20'(-ye) : 20'(ye);
        px = ax * ax;
        py = ay * ay;
        sq = (SQ_W'(px) + SQ_W'(py)) << (2 * GUARD_BITS);

        cu = '0;
        cv = '0;
        if (xe == -ONE)
        begin
            cu = ((-ye) >>> 2) - 3 * QTR;
            cv = (-ze) >>> 2;
        end
        else if (xe == ONE)
        begin
            cu = (ye >>> 2) + QTR;
            cv = (-ze) >>> 2;
        end
        else if (ye == -ONE)
        begin
            cu = (xe >>> 2) - QTR;
            cv = ((-ze) >>> 2) - 2 * QTR;
        end
        else if (ye == ONE)
        begin
            cu = ((-xe) >>> 2) - QTR;
            cv = ((-ze) >>> 2) + 2 * QTR;
        end
        else if (ze == -ONE)
        begin
            cu = (xe >>> 2) + 3 * QTR;
            cv = ye >>> 2;
        end
        else if (ze == ONE)
        begin
            cu = (xe >>> 2) - QTR;
            cv = ye >>> 2;
        end

        tag_in.x      = hit_x;
        tag_in.y      = hit_y;
        tag_in.z      = hit_z;
        tag_in.sphere = (mode_reg == MODE_SPHERE);
        tag_in.cordic = (mode_reg == MODE_SPHERE) || (mode_reg == MODE_CYLINDER);
        case (mode_reg)
            MODE_PLANE:
            begin
                tag_in.u_alt = hit_x;
                tag_in.v_alt = hit_y;
            end
            MODE_CYLINDER:
            begin
                tag_in.u_alt = '0;
                tag_in.v_alt = sat20(WIDE_W'(-ze));
            end
            MODE_CUBE:
            begin
                tag_in.u_alt = sat20(WIDE_W'(cu));
                tag_in.v_alt = sat20(WIDE_W'(cv));
            end
            default:
            begin
                tag_in.u_alt = '0;
                tag_in.v_alt = '0;
            end
        endcase
    end

    logic            sv   [0:SQRT_STEPS];
    tag_t            st   [0:SQRT_STEPS];
    logic [SQ_W-1:0] rem  [0:SQRT_STEPS];
    logic [SQ_W-1:0] root [0:SQRT_STEPS];

    logic            v0_reg;
    tag_t            tag0_reg;
    logic [SQ_W-1:0] sq0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag0_reg <= tag_in;
            sq0_reg  <= sq;
        end
    end

    assign sv[0]   = v0_reg;
    assign st[0]   = tag0_reg;
    assign rem[0]  = sq0_reg;
    assign root[0] = '0;

    // ---------------- root chain -------------------------------------------
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        tuvm_sqrt_cell #(.STEP(k)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (sv[k]),
            .in_tag   (st[k]),
            .in_rem   (rem[k]),
            .in_root  (root[k]),
            .out_valid(sv[k+1]),
            .out_tag  (st[k+1]),
            .out_rem  (rem[k+1]),
            .out_root (root[k+1])
        );
    end

    // ---------------- prescale and fold into the right half-plane ----------
    function automatic lane_t fold(input logic signed [ANG_W-1:0] x,
                                   input logic signed [ANG_W-1:0] y);
        lane_t r;
        if (x[ANG_W-1])
        begin
            r.a = y[ANG_W-1] ? -PI_Q30 : PI_Q30;
            r.x = -x;
            r.y = -y;
        end
        else
        begin
            r.a = '0;
            r.x = x;
            r.y = y;
        end
        return r;
    endfunction

    logic signed [ANG_W-1:0] gx, gy, gz, gr;
    ctag_t                   ctag_in;

    always_comb
    begin
        gx = ANG_W'(st[SQRT_STEPS].x) <<< GUARD_BITS;
        gy = ANG_W'(st[SQRT_STEPS].y) <<< GUARD_BITS;
        gz = ANG_W'(st[SQRT_STEPS].z) <<< GUARD_BITS;
        gr = ANG_W'(root[SQRT_STEPS][ROOT_W-1:0]);
        ctag_in.sphere = st[SQRT_STEPS].sphere;
        ctag_in.cordic = st[SQRT_STEPS].cordic;
        ctag_in.zero_u = (gx == '0) && (gy == '0);
        ctag_in.zero_v = (gz == '0) && (gr == '0);
        ctag_in.u_alt  = st[SQRT_STEPS].u_alt;
        ctag_in.v_alt  = st[SQRT_STEPS].v_alt;
    end

    logic  cv_ [0:CORDIC_STEPS];
    ctag_t ct  [0:CORDIC_STEPS];
    lane_t lu  [0:CORDIC_STEPS];
    lane_t lv  [0:CORDIC_STEPS];

    logic  pv_reg;
    ctag_t ptag_reg;
    lane_t pu_reg;
    lane_t pvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (en)
            pv_reg <= sv[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ptag_reg <= ctag_in;
            pu_reg   <= fold(gx, gy);
            pvl_reg  <= fold(gz, gr);
        end
    end

    assign cv_[0] = pv_reg;
    assign ct[0]  = ptag_reg;
    assign lu[0]  = pu_reg;
    assign lv[0]  = pvl_reg;

    // ---------------- rotator chain ----------------------------------------
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        tuvm_cordic_cell #(.IDX(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (cv_[i]),
            .in_tag   (ct[i]),
            .in_u     (lu[i]),
            .in_v     (lv[i]),
            .out_valid(cv_[i+1]),
            .out_tag  (ct[i+1]),
            .out_u    (lu[i+1]),
            .out_v    (lv[i+1])
        );
    end

    // ---------------- angle to pi units: split multiply --------------------
    logic [ANG_W-2:0] mu, mv;
    logic [47:0]      mu_hi, mv_hi;
    logic [48:0]      mu_lo, mv_lo;

    always_comb
    begin
        mu    = lu[CORDIC_STEPS].a[ANG_W-1] ? (ANG_W-1)'(-lu[CORDIC_STEPS].a)
                                            : (ANG_W-1)'(lu[CORDIC_STEPS].a);
        mv    = lv[CORDIC_STEPS].a[ANG_W-1] ? (ANG_W-1)'(-lv[CORDIC_STEPS].a)
                                            : (ANG_W-1)'(lv[CORDIC_STEPS].a);
        mu_hi = mu[34:18] * INV_PI_Q32;
        mu_lo = mu[17:0] * INV_PI_Q32;
        mv_hi = mv[34:18] * INV_PI_Q32;
        mv_lo = mv[17:0] * INV_PI_Q32;
    end

    logic        mv_reg;
    ctag_t       mtag_reg;
    logic        nu_reg, nv_reg;
    logic [47:0] muh_reg, mvh_reg;
    logic [48:0] mul_reg, mvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else if (en)
            mv_reg <= cv_[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mtag_reg <= ct[CORDIC_STEPS];
            nu_reg   <= lu[CORDIC_STEPS].a[ANG_W-1];
            nv_reg   <= lv[CORDIC_STEPS].a[ANG_W-1];
            muh_reg  <= mu_hi;
            mul_reg  <= mu_lo;
            mvh_reg  <= mv_hi;
            mvl_reg  <= mv_lo;
        end
    end

    // ---------------- round, sign, select, saturate ------------------------
    logic [P_W-1:0]          pu, pv;
    logic signed [WIDE_W-1:0] ru, rv;
    logic signed [DATA_W-1:0] u_fin, v_fin;

    always_comb
    begin
        pu = (P_W'(muh_reg) << 18) + P_W'(mul_reg) + (P_W'(1) << (SH_U - 1));
        pv = (P_W'(mvh_reg) << 18) + P_W'(mvl_reg) + (P_W'(1) << (SH_V - 1));
        ru = WIDE_W'(pu >> SH_U);
        rv = WIDE_W'(pv >> SH_V);
        if (nu_reg)
            ru = -ru;
        if (nv_reg)
            rv = -rv;
        if (mtag_reg.zero_u)
            ru = '0;
        if (mtag_reg.zero_v)
            rv = '0;
        u_fin = mtag_reg.cordic ? sat20(ru) : mtag_reg.u_alt;
        v_fin = mtag_reg.sphere ? sat20(rv - WIDE_W'(ONE)) : mtag_reg.v_alt;
    end

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] tex_u_reg, tex_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= mv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tex_u_reg <= u_fin;
            tex_v_reg <= v_fin;
        end
    end

    assign out_valid = out_valid_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;

    // ---------------- checks -----------------------------------------------
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tex_u) && $stable(tex_v))
        else $error("result changed while stalled");

    a_sphere_uses_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg && ptag_reg.sphere |-> ptag_reg.cordic)
        else $error("sphere item without angle path");

    a_folded_positive: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> !pu_reg.x[ANG_W-1] && !pvl_reg.x[ANG_W-1])
        else $error("rotator entered with negative x");

endmodule

// ----- tb/sv/texture_uv_mapper_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// texture_uv_mapper_tb
// Self-checking bench for the texture coordinate mapper: drives hit points in
// all four projections, predicts (u,v) with an independent fixed-point CORDIC
// model and compares every output transfer under random idling and stalls.
// ----------------------------------------------------------------------------
module texture_uv_mapper_tb;

    import tuvm_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE_Q16 = 20'sh10000;
    localparam int      PIPE_DRAIN = 60;
    localparam int      HOLD_LEN   = 400;
    localparam longint  CYCLE_CAP  = 2000000;

    typedef struct {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
    } uv_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [1:0]               cfg_wdata = 2'd0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] hit_x     = '0;
    logic signed [DATA_W-1:0] hit_y     = '0;
    logic signed [DATA_W-1:0] hit_z     = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] tex_u;
    logic signed [DATA_W-1:0] tex_v;

    map_mode_t mode_cur     = MODE_SPHERE;
    int        send_idle    = 0;
    int        recv_stall   = 0;
    bit        hold_req     = 1'b0;
    bit        hold_on      = 1'b0;
    int        fail_count   = 0;
    longint    cycle_count  = 0;
    longint    atan_q30[TBL_SIZE];
    uv_t       uv_pending[$];

    texture_uv_mapper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .hit_x     (hit_x),
        .hit_y     (hit_y),
        .hit_z     (hit_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tex_u     (tex_u),
        .tex_v     (tex_v)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic void build_atan_table();
        longint unsigned acc;
        longint unsigned term;
        bit              add;
        atan_q30[0] = 64'd843314857;
        for (int i = 1; i < TBL_SIZE; i++)
        begin
            acc = 0;
            add = 1'b1;
            for (int n = 1; 62 - i * n >= 0; n += 2)
            begin
                term = (64'd1 << (62 - i * n)) / longint'(n);
                if (add)
                    acc = acc + term;
                else
                    acc = acc - term;
                add = !add;
            end
            atan_q30[i] = longint'((acc + (64'd1 << 31)) >> 32);
        end
    endfunction

    // atan2(y,x) in Q30 radians
    function automatic longint angle_q30(longint y, longint x);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            ang = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF && i < TBL_SIZE; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                ang = ang + atan_q30[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                ang = ang - atan_q30[i];
            end
        end
        return ang;
    endfunction

    function automatic longint pi_units(longint a, int extra);
        longint unsigned mag;
        longint unsigned prod;
        longint          r;
        int              s;
        mag  = (a < 0) ? longint'(-a) : longint'(a);
        s    = 62 - FRAC_BITS_DEF - extra;
        prod = mag * longint'(INV_PI_Q32);
        r    = longint'((prod + (64'd1 << (s - 1))) >> s);
        return (a < 0) ? -r : r;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp20(longint v);
        if (v > 524287)
            return 20'sh7FFFF;
        if (v < -524288)
            return 20'sh80000;
        return v[DATA_W-1:0];
    endfunction

    function automatic uv_t predict_uv(map_mode_t m, longint x, longint y, longint z);
        longint          u;
        longint          v;
        longint          q;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned r;
        uv_t             res;
        u = 0;
        v = 0;
        q = ONE_Q16 >> 2;
        case (m)
            MODE_PLANE:
            begin
                u = x;
                v = y;
            end
            MODE_SPHERE, MODE_CYLINDER:
            begin
                u = pi_units(angle_q30(y <<< GUARD_BITS, x <<< GUARD_BITS), 0);
                if (m == MODE_CYLINDER)
                    v = -z;
                else
                begin
                    ax = (x < 0) ? -x : x;
                    ay = (y < 0) ? -y : y;
                    r  = root_floor((ax * ax + ay * ay) << (2 * GUARD_BITS));
                    v  = pi_units(angle_q30(longint'(r), z <<< GUARD_BITS), 1) - ONE_Q16;
                end
            end
            default:
            begin
                if (x == -ONE_Q16)
                begin
                    u = ((-y) >>> 2) - 3 * q;
                    v = (-z) >>> 2;
                end
                else if (x == ONE_Q16)
                begin
                    u = (y >>> 2) + q;
                    v = (-z) >>> 2;
                end
                else if (y == -ONE_Q16)
                begin
                    u = (x >>> 2) - q;
                    v = ((-z) >>> 2) - 2 * q;
                end
                else if (y == ONE_Q16)
                begin
                    u = ((-x) >>> 2) - q;
                    v = ((-z) >>> 2) + 2 * q;
                end
                else if (z == -ONE_Q16)
                begin
                    u = (x >>> 2) + 3 * q;
                    v = y >>> 2;
                end
                else if (z == ONE_Q16)
                begin
                    u = (x >>> 2) - q;
                    v = y >>> 2;
                end
            end
        endcase
        res.u = clamp20(u);
        res.v = clamp20(v);
        return res;
    endfunction

    // ---------------- output side ----------------

    always @(posedge clk)
    begin
        if (hold_on)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // long receiver hold-off, counted here so the sender keeps pushing
    always
    begin
        wait (hold_req);
        @(negedge clk);
        hold_on = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_on  = 1'b0;
        hold_req = 1'b0;
    end

    always @(posedge clk)
    begin
        uv_t exp_uv;
        if (rst_n && out_valid && out_ready)
        begin
            if (uv_pending.size() == 0)
            begin
                $error("output transfer with nothing expected: u=%0d v=%0d", tex_u, tex_v);
                fail_count++;
            end
            else
            begin
                exp_uv = uv_pending.pop_front();
                if (tex_u !== exp_uv.u)
                begin
                    $error("tex_u mismatch: expected %0d, actual %0d", exp_uv.u, tex_u);
                    fail_count++;
                end
                if (tex_v !== exp_uv.v)
                begin
                    $error("tex_v mismatch: expected %0d, actual %0d", exp_uv.v, tex_v);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- input side ----------------

    task automatic send_hit(input logic signed [DATA_W-1:0] x,
                            input logic signed [DATA_W-1:0] y,
                            input logic signed [DATA_W-1:0] z);
        int gap;
        hit_x    <= x;
        hit_y    <= y;
        hit_z    <= z;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        uv_pending.push_back(predict_uv(mode_cur, x, y, z));
        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (uv_pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic set_mode(input map_mode_t m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mode_cur   = m;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_coord(input bit cube_bias);
        int sel;
        sel = $urandom_range(cube_bias ? 9 : 15);
        case (sel)
            0:       return ONE_Q16;
            1:       return -ONE_Q16;
            2:       return 20'sh7FFFF;
            3:       return 20'sh80000;
            4:       return 0;
            5, 6:    return $signed(20'($urandom_range(2 * ONE_Q16))) - ONE_Q16;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // ---------------- tests ----------------

    task automatic test_plane();
        set_mode(MODE_PLANE);
        send_hit(20'sh7FFFF, 20'sh80000, 0);
        send_hit(20'sh80000, 20'sh7FFFF, 20'sh7FFFF);
        send_hit(0, 0, 0);
        send_hit(-1, 1, -1);
    endtask

    task automatic test_sphere();
        set_mode(MODE_SPHERE);
        send_hit(0, 0, 0);                      // origin: u = 0, v = -1
        send_hit(-ONE_Q16, 0, 0);               // negative x axis: u = +1
        send_hit(ONE_Q16, 0, ONE_Q16);
        send_hit(0, ONE_Q16, -ONE_Q16);
        send_hit(20'sh7FFFF, 20'sh7FFFF, 20'sh80000);
        send_hit(20'sh80000, 20'sh80000, 20'sh7FFFF);
        send_hit(20'sh80000, 0, 0);
        send_hit(0, 0, 20'sh80000);
    endtask

    task automatic test_cylinder();
        set_mode(MODE_CYLINDER);
        send_hit(0, 0, 20'sh80000);             // -z saturates
        send_hit(-ONE_Q16, 0, 20'sh7FFFF);
        send_hit(0, -ONE_Q16, 1);
    endtask

    task automatic test_cube();
        set_mode(MODE_CUBE);
        send_hit(-ONE_Q16, 12345, -777);
        send_hit(ONE_Q16, -3, 20'sh80000);
        send_hit(5, -ONE_Q16, 20'sh7FFFF);
        send_hit(-5, ONE_Q16, -9);
        send_hit(20'sh7FFFF, 7, -ONE_Q16);
        send_hit(20'sh80000, -7, ONE_Q16);
        send_hit(ONE_Q16, ONE_Q16, ONE_Q16);    // first face in order wins
        send_hit(3, ONE_Q16, -ONE_Q16);
        send_hit(ONE_Q16 - 1, -ONE_Q16 + 1, ONE_Q16 + 1);  // no face
    endtask

    task automatic test_random();
        map_mode_t modes[4];
        int        idle_pct[4];
        int        stall_pct[4];
        modes     = '{MODE_SPHERE, MODE_PLANE, MODE_CYLINDER, MODE_CUBE};
        idle_pct  = '{0, 75, 0, 6};
        stall_pct = '{0, 0, 75, 6};
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                set_mode(modes[(k + ph) % 4]);
                send_idle  = idle_pct[ph];
                recv_stall = stall_pct[ph];
                repeat (45)
                    send_hit(pick_coord(mode_cur == MODE_CUBE),
                             pick_coord(mode_cur == MODE_CUBE),
                             pick_coord(mode_cur == MODE_CUBE));
            end
        end
        send_idle  = 0;
        recv_stall = 0;
    endtask

    task automatic test_backpressure();
        set_mode(MODE_SPHERE);
        hold_req = 1'b1;
        repeat (100)
            send_hit(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
        drain();
    endtask

    initial
    begin
        build_atan_table();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plane();
        test_sphere();
        test_cylinder();
        test_cube();
        test_random();
        test_backpressure();
        set_mode(MODE_SPHERE);
        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tuvm_pkg.sv
src/tuvm_sqrt_cell.sv
src/tuvm_cordic_cell.sv
src/texture_uv_mapper.sv
tb/sv/texture_uv_mapper_tb.sv
